FILE: src/sips_pkg.sv
// sips_pkg: types, codes and constants of the initiator phase sequencer
// used by scsi_initiator_phase_sequencer; depends on nothing else
package sips_pkg;

  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned TickBitsDef   = 16;

  // configuration register indexes and reset values
  localparam logic [3:0] CFG_BUS_FREE   = 4'd0;
  localparam logic [3:0] CFG_SELECTION  = 4'd1;
  localparam logic [3:0] CFG_RESET_HOLD = 4'd2;
  localparam logic [3:0] CFG_PARITY_EN  = 4'd3;

  localparam logic [15:0] BusFreeTicksRst   = 16'd25;
  localparam logic [15:0] SelectionTicksRst = 16'd60;
  localparam logic [7:0]  ResetHoldTicksRst = 8'd2;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_BUSFREE = 3'd1,
    ST_SELECT  = 3'd2,
    ST_XFER    = 3'd3,
    ST_RESET   = 3'd4
  } seq_state_e;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_ABORT  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RES_OK         = 3'd0,
    RES_BAD_TARGET = 3'd1,
    RES_BUSY       = 3'd2,
    RES_NO_CONNECT = 3'd3,
    RES_RESET      = 3'd4,
    RES_PARITY     = 3'd5,
    RES_ERROR      = 3'd6,
    RES_ABORT      = 3'd7
  } result_e;

  // bus phases: bit0 I/O, bit1 C/D, bit2 MSG
  localparam logic [2:0] PH_DATA_OUT = 3'd0;
  localparam logic [2:0] PH_DATA_IN  = 3'd1;
  localparam logic [2:0] PH_COMMAND  = 3'd2;
  localparam logic [2:0] PH_STATUS   = 3'd3;
  localparam logic [2:0] PH_MSG_OUT  = 3'd6;
  localparam logic [2:0] PH_MSG_IN   = 3'd7;

  localparam logic [1:0] TOOK_NONE    = 2'd0;
  localparam logic [1:0] TOOK_COMMAND = 2'd1;
  localparam logic [1:0] TOOK_DATA    = 2'd2;

  localparam logic [1:0] GOT_NONE    = 2'd0;
  localparam logic [1:0] GOT_DATA    = 2'd1;
  localparam logic [1:0] GOT_STATUS  = 2'd2;
  localparam logic [1:0] GOT_MESSAGE = 2'd3;

  localparam logic [2:0] CTL_NONE = 3'd0;
  localparam logic [2:0] CTL_DRV  = 3'd1;
  localparam logic [2:0] CTL_SEL  = 3'd2;
  localparam logic [2:0] CTL_RST  = 3'd4;

  localparam logic [2:0] MaxTarget  = 3'd6;
  localparam logic [7:0] MsgReject  = 8'h07;
  localparam logic [7:0] MsgDone    = 8'h00;

endpackage

FILE: src/scsi_initiator_phase_sequencer.sv
// scsi_initiator_phase_sequencer: SCSI-1 initiator bus phase sequencer, no arbitration
// depends on sips_pkg
//
// path: input transfer to result through the input register, then the result register
// throughput: one item per cycle while the result side takes results; one result per item, in order
// while a result waits on the output side the input register holds one more item
// reset (rst_ni low, asynchronous): sequencer idle, counters and codes cleared,
// configuration back to bus_free 25, selection 60, reset hold 2, parity off
module scsi_initiator_phase_sequencer #(
  parameter int unsigned LENGTH_BITS = sips_pkg::LengthBitsDef,
  parameter int unsigned TICK_BITS   = sips_pkg::TickBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: target[2:0], length[18:3], abort_code[21:19], bsy[22], sel[23], req[24],
  //        phase[27:25], parity_error[28], bus_data[36:29], send_byte[44:37], zero fill
  input  logic [47:0] s_axis_tdata,
  // tuser: command[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: control_lines[2:0], drive_byte[10:3], drive_valid[11], got_byte[19:12],
  //        finished[20], result_code[23:21], scsi_status[31:24], scsi_message[39:32],
  //        bytes_left[55:40]
  output logic [55:0] m_axis_tdata,
  // tuser: took_kind[1:0], got_kind[3:2]
  output logic [3:0]  m_axis_tuser
);
  import sips_pkg::*;

  localparam int unsigned CmpW = (TICK_BITS > 16) ? TICK_BITS : 16;
  localparam logic [TICK_BITS-1:0] TickMax = {TICK_BITS{1'b1}};

  // configuration
  logic [15:0] bus_free_q, selection_q;
  logic [7:0]  hold_q;
  logic        par_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_free_q  <= BusFreeTicksRst;
      selection_q <= SelectionTicksRst;
      hold_q      <= ResetHoldTicksRst;
      par_en_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BUS_FREE:   bus_free_q  <= cfg_data_i;
        CFG_SELECTION:  selection_q <= cfg_data_i;
        CFG_RESET_HOLD: hold_q      <= cfg_data_i[7:0];
        CFG_PARITY_EN:  par_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic        in_valid_q;
  logic [47:0] in_data_q;
  logic [1:0]  in_cmd_q;
  logic        advance;
  logic        out_valid_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_cmd_q  <= s_axis_tuser;
    end
  end

  logic [2:0]  f_target;
  logic [15:0] f_length;
  logic [2:0]  f_abort_code;
  logic        f_bsy, f_sel, f_req, f_perr;
  logic [2:0]  f_phase;
  logic [7:0]  f_bus_data, f_send_byte;
  cmd_e        f_cmd;

  assign f_target     = in_data_q[2:0];
  assign f_length     = in_data_q[18:3];
  assign f_abort_code = in_data_q[21:19];
  assign f_bsy        = in_data_q[22];
  assign f_sel        = in_data_q[23];
  assign f_req        = in_data_q[24];
  assign f_phase      = in_data_q[27:25];
  assign f_perr       = in_data_q[28];
  assign f_bus_data   = in_data_q[36:29];
  assign f_send_byte  = in_data_q[44:37];
  assign f_cmd        = cmd_e'(in_cmd_q);

  // sequencer state
  seq_state_e             state_q, state_d;
  logic [TICK_BITS-1:0]   tick_q, tick_d, tick_inc;
  logic [2:0]             target_q, target_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;
  logic [7:0]             status_q, status_d;
  logic [7:0]             message_q, message_d;
  logic [2:0]             pending_q, pending_d;
  logic [2:0]             control_q, control_d;

  // result fields of the item in the input register
  logic [7:0] drive;
  logic       dvalid;
  logic [1:0] took, gkind;
  logic [7:0] got;
  logic       fin;
  logic [2:0] fin_code;
  logic [2:0] abort_val;
  logic [CmpW-1:0] tick_cmp;
  logic       hit_bus_free, hit_select, hit_hold;
  logic       done;

  assign tick_inc     = (tick_q == TickMax) ? tick_q : tick_q + 1'b1;
  assign tick_cmp     = CmpW'(tick_inc);
  assign hit_bus_free = tick_cmp >= CmpW'(bus_free_q);
  assign hit_select   = tick_cmp >= CmpW'(selection_q);
  assign hit_hold     = tick_cmp >= CmpW'(hold_q);
  assign abort_val    = (f_abort_code != 3'd0) ? f_abort_code : RES_ABORT;

  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    target_d  = target_q;
    remain_d  = remain_q;
    status_d  = status_q;
    message_d = message_q;
    pending_d = pending_q;
    control_d = control_q;
    drive     = 8'd0;
    dvalid    = 1'b0;
    took      = TOOK_NONE;
    got       = 8'd0;
    gkind     = GOT_NONE;
    fin       = 1'b0;
    fin_code  = RES_OK;
    done      = 1'b0;

    case (f_cmd)
      CMD_START: begin
        if (state_q == ST_IDLE) begin
          target_d  = f_target;
          remain_d  = LENGTH_BITS'(f_length);
          status_d  = 8'd0;
          message_d = 8'd0;
          pending_d = 3'd0;
          tick_d    = '0;
          control_d = CTL_NONE;
          if (f_target > MaxTarget) begin
            fin      = 1'b1;
            fin_code = RES_BAD_TARGET;
          end else begin
            state_d = ST_BUSFREE;
          end
        end
      end
      CMD_ABORT: begin
        if (state_q inside {ST_BUSFREE, ST_SELECT, ST_XFER}) begin
          pending_d = abort_val;
          if (state_q == ST_BUSFREE) begin
            fin      = 1'b1;
            fin_code = abort_val;
          end
        end
      end
      CMD_TICK: begin
        case (state_q)
          ST_BUSFREE: begin
            tick_d = tick_inc;
            if (hit_bus_free) begin
              fin      = 1'b1;
              fin_code = RES_BUSY;
            end
          end
          ST_SELECT: begin
            tick_d = tick_inc;
            if (hit_select) begin
              fin      = 1'b1;
              fin_code = RES_NO_CONNECT;
            end
          end
          ST_RESET: begin
            tick_d = tick_inc;
            if (hit_hold) begin
              fin      = 1'b1;
              fin_code = RES_RESET;
            end
          end
          default: ;
        endcase
      end
      default: begin
        // bus sample
        if (state_q == ST_BUSFREE) begin
          if (!f_bsy && !f_sel) begin
            state_d   = ST_SELECT;
            tick_d    = '0;
            drive     = 8'd1 << target_q;
            dvalid    = 1'b1;
            control_d = CTL_DRV | CTL_SEL;
          end
        end else if (state_q == ST_SELECT || (state_q == ST_XFER && pending_q != 3'd0)) begin
          // a pending abort or fault is resolved by this sample
          if (pending_q != 3'd0) begin
            if (f_bsy) begin
              state_d   = ST_RESET;
              control_d = CTL_RST;
              tick_d    = '0;
            end else begin
              fin      = 1'b1;
              fin_code = pending_q;
            end
          end else if (f_bsy) begin
            state_d   = ST_XFER;
            control_d = CTL_DRV;
          end
        end else if (state_q == ST_XFER) begin
          if (!f_bsy) begin
            fin      = 1'b1;
            fin_code = RES_OK;
          end else begin
            if (par_en_q && f_perr) pending_d = RES_PARITY;
            if (f_req) begin
              case (f_phase)
                PH_DATA_OUT: begin
                  if (remain_q != '0) begin
                    drive    = f_send_byte;
                    dvalid   = 1'b1;
                    took     = TOOK_DATA;
                    remain_d = remain_q - 1'b1;
                  end
                end
                PH_DATA_IN: begin
                  if (remain_q != '0) begin
                    got      = f_bus_data;
                    gkind    = GOT_DATA;
                    remain_d = remain_q - 1'b1;
                  end
                end
                PH_COMMAND: begin
                  drive  = f_send_byte;
                  dvalid = 1'b1;
                  took   = TOOK_COMMAND;
                end
                PH_STATUS: begin
                  status_d = f_bus_data;
                  got      = f_bus_data;
                  gkind    = GOT_STATUS;
                end
                PH_MSG_OUT: begin
                  drive  = MsgReject;
                  dvalid = 1'b1;
                end
                PH_MSG_IN: begin
                  message_d = f_bus_data;
                  got       = f_bus_data;
                  gkind     = GOT_MESSAGE;
                  done      = (f_bus_data == MsgDone);
                end
                default: pending_d = RES_ERROR;
              endcase
            end
            if (done && pending_d == 3'd0) begin
              fin      = 1'b1;
              fin_code = RES_OK;
            end
          end
        end
      end
    endcase

    // ending a command returns the sequencer to idle
    if (fin) begin
      state_d   = ST_IDLE;
      control_d = CTL_NONE;
      pending_d = 3'd0;
      tick_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tick_q    <= '0;
      target_q  <= 3'd0;
      remain_q  <= '0;
      status_q  <= 8'd0;
      message_q <= 8'd0;
      pending_q <= 3'd0;
      control_q <= CTL_NONE;
    end else if (advance) begin
      state_q   <= state_d;
      tick_q    <= tick_d;
      target_q  <= target_d;
      remain_q  <= remain_d;
      status_q  <= status_d;
      message_q <= message_d;
      pending_q <= pending_d;
      control_q <= control_d;
    end
  end

  // result register
  logic [15:0] bytes_left;

  assign bytes_left = 16'(remain_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_axis_tdata <= {bytes_left, message_d, status_d, fin_code, fin, got, dvalid, drive,
                       control_d};
      m_axis_tuser <= {gkind, took};
    end
  end

  assign m_axis_tvalid = out_valid_q;

  // a stalled item stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input register lost an item under stall");

  // the reset pulse drives bus reset alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RESET |-> control_q == CTL_RST)
    else $error("reset state without bus reset control");

  // idle means nothing pending and no lines driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> pending_q == 3'd0 && control_q == CTL_NONE)
    else $error("idle with pending code or driven lines");

  // a finished command releases every control line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && m_axis_tdata[20] |-> m_axis_tdata[2:0] == CTL_NONE)
    else $error("finished result with control lines still driven");

endmodule

FILE: tb/sips_phase_checker.sv
// sips_phase_checker: watches the config, input and result channels of the phase
// sequencer, keeps its own model of the sequencer and compares every result transfer
// depends on sips_pkg
`timescale 1ns / 1ps

module sips_phase_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,
  input  logic [3:0]  m_tuser_i,
  output int          error_count_o,
  output int          pending_o,
  output int          results_o,
  output int          endings_o
);
  import sips_pkg::*;

  typedef struct packed {
    logic [2:0]  ctl;
    logic [7:0]  drive;
    logic        dvalid;
    logic [1:0]  took;
    logic [7:0]  got;
    logic [1:0]  gkind;
    logic        fin;
    logic [2:0]  code;
    logic [7:0]  status;
    logic [7:0]  message;
    logic [15:0] left;
  } phase_result_t;

  // model state
  seq_state_e  seq_q;
  logic [15:0] tick_q;
  logic [2:0]  tgt_q;
  logic [15:0] left_q;
  logic [7:0]  status_q;
  logic [7:0]  msg_q;
  logic [2:0]  pend_q;
  logic [2:0]  ctl_q;
  logic [15:0] bus_free_lim;
  logic [15:0] select_lim;
  logic [7:0]  hold_lim;
  logic        parity_en;

  logic        ended;
  logic [2:0]  end_code;

  phase_result_t expected_q[$];
  int n_errors;
  int n_results;
  int n_endings;

  function automatic void end_command(logic [2:0] code);
    ended    = 1'b1;
    end_code = code;
    seq_q    = ST_IDLE;
    ctl_q    = CTL_NONE;
    pend_q   = 3'd0;
    tick_q   = 16'd0;
  endfunction

  // saturating tick count, limit reached once the count is at or above it
  function automatic logic tick_reached(logic [15:0] limit);
    if (tick_q != 16'hffff) tick_q = tick_q + 16'd1;
    return tick_q >= limit;
  endfunction

  function automatic phase_result_t step_sequencer(cmd_e cmd, logic [47:0] d);
    phase_result_t r;
    logic [2:0]  tgt;
    logic [15:0] len;
    logic [2:0]  acode;
    logic        bsy;
    logic        sel;
    logic        req;
    logic [2:0]  ph;
    logic        perr;
    logic [7:0]  bdata;
    logic [7:0]  sbyte;
    logic        msg_done;
    r        = '0;
    tgt      = d[2:0];
    len      = d[18:3];
    acode    = d[21:19];
    bsy      = d[22];
    sel      = d[23];
    req      = d[24];
    ph       = d[27:25];
    perr     = d[28];
    bdata    = d[36:29];
    sbyte    = d[44:37];
    msg_done = 1'b0;
    ended    = 1'b0;
    end_code = 3'd0;

    case (cmd)
      CMD_START: begin
        if (seq_q == ST_IDLE) begin
          tgt_q    = tgt;
          left_q   = len;
          status_q = 8'd0;
          msg_q    = 8'd0;
          pend_q   = 3'd0;
          tick_q   = 16'd0;
          ctl_q    = CTL_NONE;
          if (tgt > MaxTarget) end_command(RES_BAD_TARGET);
          else seq_q = ST_BUSFREE;
        end
      end
      CMD_ABORT: begin
        if (seq_q == ST_BUSFREE || seq_q == ST_SELECT || seq_q == ST_XFER) begin
          pend_q = (acode != 3'd0) ? acode : RES_ABORT;
          if (seq_q == ST_BUSFREE) end_command(pend_q);
        end
      end
      CMD_TICK: begin
        if (seq_q == ST_BUSFREE) begin
          if (tick_reached(bus_free_lim)) end_command(RES_BUSY);
        end else if (seq_q == ST_SELECT) begin
          if (tick_reached(select_lim)) end_command(RES_NO_CONNECT);
        end else if (seq_q == ST_RESET) begin
          if (tick_reached({8'd0, hold_lim})) end_command(RES_RESET);
        end
      end
      default: begin
        if (seq_q == ST_BUSFREE) begin
          if (!bsy && !sel) begin
            seq_q    = ST_SELECT;
            tick_q   = 16'd0;
            r.drive  = 8'h01 << tgt_q;
            r.dvalid = 1'b1;
            ctl_q    = CTL_DRV | CTL_SEL;
          end
        end else if (seq_q == ST_SELECT || (seq_q == ST_XFER && pend_q != 3'd0)) begin
          // a pending abort or fault is resolved by this sample
          if (pend_q != 3'd0) begin
            if (bsy) begin
              seq_q  = ST_RESET;
              ctl_q  = CTL_RST;
              tick_q = 16'd0;
            end else begin
              end_command(pend_q);
            end
          end else if (bsy) begin
            seq_q = ST_XFER;
            ctl_q = CTL_DRV;
          end
        end else if (seq_q == ST_XFER) begin
          if (!bsy) begin
            end_command(RES_OK);
          end else begin
            if (parity_en && perr) pend_q = RES_PARITY;
            if (req) begin
              case (ph)
                PH_DATA_OUT: begin
                  if (left_q != 16'd0) begin
                    r.drive  = sbyte;
                    r.dvalid = 1'b1;
                    r.took   = TOOK_DATA;
                    left_q   = left_q - 16'd1;
                  end
                end
                PH_DATA_IN: begin
                  if (left_q != 16'd0) begin
                    r.got   = bdata;
                    r.gkind = GOT_DATA;
                    left_q  = left_q - 16'd1;
                  end
                end
                PH_COMMAND: begin
                  r.drive  = sbyte;
                  r.dvalid = 1'b1;
                  r.took   = TOOK_COMMAND;
                end
                PH_STATUS: begin
                  status_q = bdata;
                  r.got    = bdata;
                  r.gkind  = GOT_STATUS;
                end
                PH_MSG_OUT: begin
                  r.drive  = MsgReject;
                  r.dvalid = 1'b1;
                end
                PH_MSG_IN: begin
                  msg_q   = bdata;
                  r.got   = bdata;
                  r.gkind = GOT_MESSAGE;
                  msg_done = (bdata == MsgDone);
                end
                default: pend_q = RES_ERROR;
              endcase
            end
            if (msg_done && pend_q == 3'd0) end_command(RES_OK);
          end
        end
      end
    endcase

    r.ctl     = ctl_q;
    r.fin     = ended;
    r.code    = ended ? end_code : 3'd0;
    r.status  = status_q;
    r.message = msg_q;
    r.left    = left_q;
    return r;
  endfunction

  function automatic string fmt_result(phase_result_t r);
    return $sformatf({"ctl=%0d drv=%h/%b took=%0d got=%h/%0d fin=%b code=%0d",
                      " st=%h msg=%h left=%0d"},
                     r.ctl, r.drive, r.dvalid, r.took, r.got, r.gkind, r.fin, r.code,
                     r.status, r.message, r.left);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    phase_result_t act;
    phase_result_t exp_r;
    if (!rst_ni) begin
      seq_q        = ST_IDLE;
      tick_q       = 16'd0;
      tgt_q        = 3'd0;
      left_q       = 16'd0;
      status_q     = 8'd0;
      msg_q        = 8'd0;
      pend_q       = 3'd0;
      ctl_q        = CTL_NONE;
      bus_free_lim = BusFreeTicksRst;
      select_lim   = SelectionTicksRst;
      hold_lim     = ResetHoldTicksRst;
      parity_en    = 1'b0;
      expected_q.delete();
      n_errors     = 0;
      n_results    = 0;
      n_endings    = 0;
    end else begin
      // compare first: a result never belongs to the item accepted at the same edge
      if (m_tvalid_i && m_tready_i) begin
        act.ctl     = m_tdata_i[2:0];
        act.drive   = m_tdata_i[10:3];
        act.dvalid  = m_tdata_i[11];
        act.got     = m_tdata_i[19:12];
        act.fin     = m_tdata_i[20];
        act.code    = m_tdata_i[23:21];
        act.status  = m_tdata_i[31:24];
        act.message = m_tdata_i[39:32];
        act.left    = m_tdata_i[55:40];
        act.took    = m_tuser_i[1:0];
        act.gkind   = m_tuser_i[3:2];
        n_results++;
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result transfer %0d: %s", n_results, fmt_result(act));
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.fin) n_endings++;
          if (act !== exp_r) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch on result transfer %0d", n_results);
              $display("  expected %s", fmt_result(exp_r));
              $display("  actual   %s", fmt_result(act));
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_q.push_back(step_sequencer(cmd_e'(s_tuser_i), s_tdata_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BUS_FREE:   bus_free_lim = cfg_data_i;
          CFG_SELECTION:  select_lim   = cfg_data_i;
          CFG_RESET_HOLD: hold_lim     = cfg_data_i[7:0];
          CFG_PARITY_EN:  parity_en    = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    error_count_o <= n_errors;
    pending_o     <= expected_q.size();
    results_o     <= n_results;
    endings_o     <= n_endings;
  end

endmodule

FILE: tb/tb_scsi_initiator_phase_sequencer.sv
// tb_scsi_initiator_phase_sequencer: stimulus and verdict for the phase sequencer;
// drives directed and random bus command sequences, checking is done in sips_phase_checker
// depends on sips_pkg, sips_phase_checker and scsi_initiator_phase_sequencer
`timescale 1ns / 1ps

module tb_scsi_initiator_phase_sequencer;
  import sips_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct {
    cmd_e        cmd;
    logic [2:0]  target;
    logic [15:0] length;
    logic [2:0]  abort_code;
    logic        bsy;
    logic        sel;
    logic        req;
    logic [2:0]  phase;
    logic        parity_error;
    logic [7:0]  bus_data;
    logic [7:0]  send_byte;
  } seq_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  int   error_count;
  int   pending_results;
  int   results_seen;
  int   commands_ended;
  int   items_sent;
  int   settings_used;
  logic stall_en;
  logic [7:0] hold_cfg;

  scsi_initiator_phase_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  sips_phase_checker phase_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .error_count_o(error_count),
    .pending_o    (pending_results),
    .results_o    (results_seen),
    .endings_o    (commands_ended)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[scsi_initiator_phase_sequencer] ERROR");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= !(stall_en && ($urandom_range(0, 99) < 10));
  end

  function automatic seq_item_t any_item();
    seq_item_t it;
    it.cmd          = cmd_e'($urandom_range(0, 3));
    it.target       = 3'($urandom);
    it.length       = 16'($urandom);
    it.abort_code   = 3'($urandom);
    it.bsy          = 1'($urandom);
    it.sel          = 1'($urandom);
    it.req          = 1'($urandom);
    it.phase        = 3'($urandom);
    it.parity_error = 1'($urandom);
    it.bus_data     = 8'($urandom);
    it.send_byte    = 8'($urandom);
    return it;
  endfunction

  function automatic seq_item_t mk_start(logic [2:0] tgt, logic [15:0] len);
    seq_item_t it;
    it        = any_item();
    it.cmd    = CMD_START;
    it.target = tgt;
    it.length = len;
    return it;
  endfunction

  function automatic seq_item_t mk_tick();
    seq_item_t it;
    it     = any_item();
    it.cmd = CMD_TICK;
    return it;
  endfunction

  function automatic seq_item_t mk_abort(logic [2:0] code);
    seq_item_t it;
    it            = any_item();
    it.cmd        = CMD_ABORT;
    it.abort_code = code;
    return it;
  endfunction

  function automatic seq_item_t mk_sample(logic bsy, logic sel, logic req, logic [2:0] ph,
                                          logic [7:0] bdata, logic [7:0] sbyte);
    seq_item_t it;
    it           = any_item();
    it.cmd       = CMD_SAMPLE;
    it.bsy       = bsy;
    it.sel       = sel;
    it.req       = req;
    it.phase     = ph;
    it.bus_data  = bdata;
    it.send_byte = sbyte;
    return it;
  endfunction

  // occasionally replace a well-formed step by an arbitrary item
  function automatic seq_item_t noisy(seq_item_t it);
    return ($urandom_range(0, 99) < 8) ? any_item() : it;
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'hffff;
    if (r < 10) return 16'($urandom);
    if (r < 15) return 16'd0;
    return 16'($urandom_range(1, 6));
  endfunction

  function automatic seq_item_t xfer_sample();
    seq_item_t it;
    logic [2:0] ph;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return mk_abort(3'($urandom));
    if (r < 8) ph = 3'($urandom_range(4, 5));
    else begin
      case ($urandom_range(0, 5))
        0: ph = PH_DATA_OUT;
        1: ph = PH_DATA_IN;
        2: ph = PH_COMMAND;
        3: ph = PH_STATUS;
        4: ph = PH_MSG_OUT;
        default: ph = PH_MSG_IN;
      endcase
    end
    it = mk_sample($urandom_range(0, 99) < 95, 1'($urandom), $urandom_range(0, 99) < 85, ph,
                   8'($urandom), 8'($urandom));
    // keep message-in going most of the time, command complete comes at the end
    if (ph == PH_MSG_IN && $urandom_range(0, 9) != 0) it.bus_data = 8'($urandom_range(1, 255));
    it.parity_error = $urandom_range(0, 99) < 6;
    return it;
  endfunction

  task automatic send_item(seq_item_t it);
    while (stall_en && ($urandom_range(0, 99) < 10)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {3'b000, it.send_byte, it.bus_data, it.parity_error, it.phase, it.req,
                      it.sel, it.bsy, it.abort_code, it.length, it.target};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(logic [15:0] bus_free, logic [15:0] selection, logic [7:0] hold,
                              logic parity);
    drain_results();
    write_reg(CFG_BUS_FREE, bus_free);
    write_reg(CFG_SELECTION, selection);
    write_reg(CFG_RESET_HOLD, {8'd0, hold});
    write_reg(CFG_PARITY_EN, {15'd0, parity});
    cfg_valid_i <= 1'b0;
    hold_cfg = hold;
    settings_used++;
  endtask

  // one command from start to a forced return to idle
  task automatic run_command();
    int r;
    send_item(mk_start(($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
                       pick_length()));
    repeat ($urandom_range(0, 4)) send_item(noisy(mk_tick()));
    if ($urandom_range(0, 4) == 0)
      send_item(noisy(mk_sample(1'b1, 1'($urandom), 1'($urandom), 3'($urandom), 8'($urandom),
                                8'($urandom))));
    send_item(noisy(mk_sample(1'b0, 1'b0, 1'($urandom), 3'($urandom), 8'($urandom),
                              8'($urandom))));
    repeat ($urandom_range(0, 3)) send_item(noisy(mk_tick()));
    send_item(noisy(mk_sample(1'b1, 1'($urandom), 1'($urandom), 3'($urandom), 8'($urandom),
                              8'($urandom))));
    repeat ($urandom_range(2, 10)) send_item(noisy(xfer_sample()));
    r = $urandom_range(0, 9);
    if (r < 6) send_item(mk_sample(1'b1, 1'($urandom), 1'b1, PH_MSG_IN, MsgDone, 8'($urandom)));
    else if (r < 8)
      send_item(mk_sample(1'b0, 1'($urandom), 1'($urandom), 3'($urandom), 8'($urandom),
                          8'($urandom)));
    // whatever state is left: abort, release BSY, then let a reset pulse run out
    send_item(mk_abort(3'($urandom)));
    send_item(mk_sample(1'b0, 1'($urandom), 1'($urandom), 3'($urandom), 8'($urandom),
                        8'($urandom)));
    repeat (hold_cfg) send_item(mk_tick());
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= 4'd0;
    cfg_data_i    <= 16'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 48'd0;
    s_axis_tuser  <= CMD_START;
    stall_en      = 1'b1;
    hold_cfg      = ResetHoldTicksRst;
    items_sent    = 0;
    settings_used = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bad target, full transfer walk, fault to reset pulse, aborts, command complete
    send_item(mk_start(3'd7, 16'hffff));
    send_item(mk_start(3'd0, 16'd2));
    send_item(mk_sample(1'b1, 1'b0, 1'b0, PH_DATA_OUT, 8'h00, 8'h00));
    send_item(mk_sample(1'b0, 1'b0, 1'b0, PH_DATA_OUT, 8'h00, 8'h00));
    send_item(mk_tick());
    send_item(mk_sample(1'b1, 1'b0, 1'b0, PH_DATA_OUT, 8'h00, 8'h00));
    send_item(mk_sample(1'b1, 1'b1, 1'b1, PH_COMMAND, 8'h00, 8'hff));
    send_item(mk_sample(1'b1, 1'b0, 1'b1, PH_DATA_OUT, 8'hff, 8'h00));
    send_item(mk_sample(1'b1, 1'b0, 1'b1, PH_DATA_IN, 8'hff, 8'h00));
    send_item(mk_sample(1'b1, 1'b0, 1'b1, PH_DATA_OUT, 8'h00, 8'hff));
    send_item(mk_sample(1'b1, 1'b0, 1'b1, PH_MSG_OUT, 8'h00, 8'h00));
    send_item(mk_sample(1'b1, 1'b0, 1'b1, PH_STATUS, 8'h80, 8'h00));
    send_item(mk_sample(1'b1, 1'b0, 1'b1, 3'd4, 8'h00, 8'h00));
    send_item(mk_sample(1'b1, 1'b0, 1'b1, PH_DATA_IN, 8'h00, 8'h00));
    send_item(mk_start(3'd1, 16'd1));
    send_item(mk_tick());
    send_item(mk_tick());
    send_item(mk_start(3'd6, 16'd0));
    send_item(mk_abort(3'd0));
    send_item(mk_start(3'd5, 16'd3));
    send_item(mk_sample(1'b0, 1'b0, 1'b0, PH_DATA_OUT, 8'h00, 8'h00));
    send_item(mk_abort(3'd3));
    send_item(mk_sample(1'b0, 1'b0, 1'b0, PH_DATA_OUT, 8'h00, 8'h00));
    send_item(mk_start(3'd2, 16'd1));
    send_item(mk_sample(1'b0, 1'b0, 1'b0, 3'd5, 8'h00, 8'h00));
    send_item(mk_sample(1'b1, 1'b0, 1'b0, 3'd5, 8'h00, 8'h00));
    send_item(mk_sample(1'b1, 1'b0, 1'b1, PH_MSG_IN, MsgDone, 8'h00));

    // random phases over several register settings
    repeat (2) run_command();
    drain_results();
    repeat (2) run_command();
    program_regs(16'd0, 16'd0, 8'd1, 1'b1);
    repeat (4) run_command();
    program_regs(16'hffff, 16'hffff, 8'd20, 1'b0);
    repeat (2) run_command();
    stall_en = 1'b0;
    program_regs(16'd3, 16'd2, 8'd3, 1'b1);
    repeat (6) run_command();
    stall_en = 1'b1;
    repeat (2) begin
      program_regs(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                   8'($urandom_range(1, 4)), 1'($urandom));
      repeat (2) run_command();
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("covered %0d input transfers and %0d result transfers under %0d register settings",
             items_sent, results_seen, settings_used);
    $display("%0d commands ran to an ending, %0d results still outstanding",
             commands_ended, pending_results);
    if (error_count == 0 && pending_results == 0) begin
      $display("[scsi_initiator_phase_sequencer] OK");
    end else begin
      $display("[scsi_initiator_phase_sequencer] ERROR");
    end
    $finish;
  end

endmodule
